@@ hdl/etf_pkg.sv @@
// ----------------------------------------------------------------------------
// etf_pkg
// Shared types, widths and the tanh lookup table for the tangent refine core.
// ----------------------------------------------------------------------------
package etf_pkg;

  localparam int COL_W     = 9;
  localparam int ROW_W     = 9;
  localparam int ADDR_W    = COL_W + ROW_W;
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int VEC_W     = 16;
  localparam int MAG_W     = 12;
  localparam int SIZE_W    = 10;
  localparam int RAD_W     = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 10;
  localparam int WORD_W    = MAG_W + 2 * VEC_W;
  localparam int SUM_W     = 64;
  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int MAX_RADIUS = 7;
  localparam int TANH_SIZE  = 1024;
  localparam int TANH_IDX_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd2;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } etf_func_e;

  typedef struct packed {
    etf_func_e                func;
    logic                     outside;
    logic [COL_W-1:0]         col;
    logic [ROW_W-1:0]         row;
    logic signed [VEC_W-1:0]  tx;
    logic signed [VEC_W-1:0]  ty;
    logic [MAG_W-1:0]         mag;
  } etf_cmd_t;

  typedef struct packed {
    logic                     zero;
    logic signed [SUM_W-1:0]  sx;
    logic signed [SUM_W-1:0]  sy;
  } etf_sum_t;

  typedef logic [15:0] tanh_lut_t [TANH_SIZE];

  // shift and subtract quotient, used only while the table is built
  function automatic logic [63:0] udiv64(logic [63:0] a, logic [63:0] b);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], a[i]};
      if (rem >= {1'b0, b}) begin
        rem  = rem - {1'b0, b};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // round(2^15 * tanh(k / TANH_SIZE)), exp from a truncated Taylor series in Q.30
  function automatic tanh_lut_t build_tanh();
    tanh_lut_t  t;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] num;
    logic [63:0] den;
    for (int k = 0; k < TANH_SIZE; k++) begin
      x    = (64'(k) << 30) >> TANH_IDX_W;
      y    = 2 * x;
      sum  = '0;
      term = 64'd1 << 30;
      for (int n = 1; n <= 30; n++) begin
        sum  = sum + term;
        term = udiv64((term * y) >> 30, 64'(n));
      end
      num  = (sum - (64'd1 << 30)) << 15;
      den  = sum + (64'd1 << 30);
      t[k] = 16'(udiv64(num + (den >> 1), den));
    end
    return t;
  endfunction

  localparam tanh_lut_t TANH_LUT = build_tanh();

endpackage

@@ hdl/etf_ram.sv @@
// ----------------------------------------------------------------------------
// etf_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module etf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/etf_front.sv @@
// ----------------------------------------------------------------------------
// etf_front
// Accept items, mark queries outside the image, hold them in a short queue.
// ----------------------------------------------------------------------------
module etf_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  etf_pkg::etf_func_e            func_i,
  input  logic [etf_pkg::COL_W-1:0]     col_i,
  input  logic [etf_pkg::ROW_W-1:0]     row_i,
  input  logic signed [etf_pkg::VEC_W-1:0] tangent_x_i,
  input  logic signed [etf_pkg::VEC_W-1:0] tangent_y_i,
  input  logic [etf_pkg::MAG_W-1:0]     magnitude_i,
  input  logic [etf_pkg::SIZE_W-1:0]    width_i,
  input  logic [etf_pkg::SIZE_W-1:0]    height_i,
  output logic                          cmd_valid_o,
  output etf_pkg::etf_cmd_t             cmd_o,
  input  logic                          cmd_pop_i
);
  import etf_pkg::*;

  etf_cmd_t slot_q [2];
  logic     wptr_q, rptr_q;
  logic [1:0] cnt_q;
  etf_cmd_t cmd_in;
  logic     push;
  logic     pop;

  always_comb begin
    cmd_in.func    = func_i;
    cmd_in.col     = col_i;
    cmd_in.row     = row_i;
    cmd_in.tx      = tangent_x_i;
    cmd_in.ty      = tangent_y_i;
    cmd_in.mag     = magnitude_i;
    cmd_in.outside = ({1'b0, col_i} >= width_i) || ({1'b0, row_i} >= height_i);
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = cmd_pop_i && (cnt_q != 2'd0);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= !wptr_q;
      if (pop)  rptr_q <= !rptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ hdl/etf_back.sv @@
// ----------------------------------------------------------------------------
// etf_back
// Execute loads and sweep the query window, accumulating the weighted sum.
// ----------------------------------------------------------------------------
module etf_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  input  etf_pkg::etf_cmd_t          cmd_i,
  output logic                       cmd_pop_o,
  input  logic [etf_pkg::SIZE_W-1:0] width_i,
  input  logic [etf_pkg::SIZE_W-1:0] height_i,
  input  logic [etf_pkg::RAD_W-1:0]  radius_i,
  output logic                       sum_valid_o,
  output etf_pkg::etf_sum_t          sum_o,
  input  logic                       sum_ready_i
);
  import etf_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CTR   = 3'd1;
  localparam logic [2:0] ST_SWEEP = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_SEND  = 3'd4;
  localparam int         OFS_W    = RAD_W + 1;
  localparam int         POS_W    = SIZE_W + 1;
  localparam logic [2:0] DRAIN_N  = 3'd7;

  logic [2:0]              state_q, state_d;
  logic [COL_W-1:0]        col_q;
  logic [ROW_W-1:0]        row_q;
  logic                    zero_q;
  logic signed [VEC_W-1:0] cx_q, cy_q;
  logic [MAG_W-1:0]        cm_q;
  logic signed [OFS_W-1:0] dr_q, dc_q;
  logic [2:0]              drain_q;
  logic signed [SUM_W-1:0] sx_q, sy_q;

  logic                 we;
  logic [ADDR_W-1:0]    raddr;
  logic [WORD_W-1:0]    rdata;

  logic signed [OFS_W-1:0] rad_s;
  logic [2*OFS_W-1:0]      dist2, rad2;
  logic signed [POS_W:0]   r, c;
  logic                    tap_ok;
  logic                    last_tap;

  // pipeline registers
  logic                    v1_q, v2_q, v3_q, v4_q, v5_q;
  logic signed [31:0]      px2_q, py2_q;
  logic signed [VEC_W-1:0] nx2_q, ny2_q, nx3_q, ny3_q, nx4_q, ny4_q;
  logic signed [MAG_W:0]   d2_q;
  logic [17:0]             wd3_q;
  logic [16:0]             wm3_q;
  logic                    neg3_q, neg4_q;
  logic [34:0]             wgt4_q;
  logic signed [51:0]      tx5_q, ty5_q;

  logic signed [VEC_W-1:0] nx, ny;
  logic [MAG_W-1:0]        nm;
  logic signed [32:0]      dot;
  logic [32:0]             adot;
  logic [MAG_W:0]          ad;
  logic [15:0]             th;
  logic signed [51:0]      prx, pry;

  etf_ram #(.WIDTH(WORD_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i ({cmd_i.row, cmd_i.col}),
    .wdata_i ({cmd_i.mag, cmd_i.ty, cmd_i.tx}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign nx = rdata[VEC_W-1:0];
  assign ny = rdata[2*VEC_W-1:VEC_W];
  assign nm = rdata[WORD_W-1:2*VEC_W];

  // window geometry for the current tap
  always_comb begin
    rad_s    = $signed({1'b0, radius_i});
    dist2    = (2*OFS_W)'(dr_q * dr_q) + (2*OFS_W)'(dc_q * dc_q);
    rad2     = (2*OFS_W)'(rad_s * rad_s);
    r        = $signed({3'b0, row_q}) + (POS_W+1)'(dr_q);
    c        = $signed({3'b0, col_q}) + (POS_W+1)'(dc_q);
    tap_ok   = (dist2 < rad2) && !r[POS_W] && !c[POS_W] &&
               (r < $signed({2'b0, height_i})) && (c < $signed({2'b0, width_i}));
    last_tap = (dr_q == rad_s) && (dc_q == rad_s);
  end

  always_comb begin
    state_d   = state_q;
    cmd_pop_o = 1'b0;
    we        = 1'b0;
    raddr     = {cmd_i.row, cmd_i.col};
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.func == FUNC_LOAD) begin
            we = 1'b1;
          end else if (cmd_i.outside) begin
            state_d = ST_SEND;
          end else begin
            state_d = ST_CTR;
          end
        end
      end
      ST_CTR:   state_d = ST_SWEEP;
      ST_SWEEP: begin
        raddr = {r[ROW_W-1:0], c[COL_W-1:0]};
        if (last_tap) state_d = ST_DRAIN;
      end
      ST_DRAIN: if (drain_q == DRAIN_N) state_d = ST_SEND;
      ST_SEND:  if (sum_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    dot  = 33'(px2_q) + 33'(py2_q);
    adot = dot[32] ? 33'(-dot) : 33'(dot);
    ad   = d2_q[MAG_W] ? 13'(-d2_q) : 13'(d2_q);
    th   = TANH_LUT[ad[MAG_W-1:MAG_W-TANH_IDX_W]];
    prx  = nx4_q * $signed({1'b0, wgt4_q});
    pry  = ny4_q * $signed({1'b0, wgt4_q});
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && cmd_valid_i) begin
      col_q  <= cmd_i.col;
      row_q  <= cmd_i.row;
      zero_q <= cmd_i.outside;
    end
    if (state_q == ST_CTR) begin
      cx_q <= nx;
      cy_q <= ny;
      cm_q <= nm;
    end
    px2_q  <= cx_q * nx;
    py2_q  <= cy_q * ny;
    nx2_q  <= nx;
    ny2_q  <= ny;
    d2_q   <= $signed({1'b0, nm}) - $signed({1'b0, cm_q});
    wd3_q  <= adot[31:14];
    wm3_q  <= d2_q[MAG_W] ? 17'd32768 - 17'(th) : 17'd32768 + 17'(th);
    neg3_q <= dot[32] || (dot == '0);
    nx3_q  <= nx2_q;
    ny3_q  <= ny2_q;
    wgt4_q <= 35'(wd3_q) * 35'(wm3_q);
    neg4_q <= neg3_q;
    nx4_q  <= nx3_q;
    ny4_q  <= ny3_q;
    tx5_q  <= neg4_q ? -prx : prx;
    ty5_q  <= neg4_q ? -pry : pry;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      dr_q    <= '0;
      dc_q    <= '0;
      drain_q <= '0;
      sx_q    <= '0;
      sy_q    <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= (state_q == ST_SWEEP) && tap_ok;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      v5_q    <= v4_q;
      if (v5_q) begin
        sx_q <= sx_q + SUM_W'(tx5_q);
        sy_q <= sy_q + SUM_W'(ty5_q);
      end
      case (state_q)
        ST_IDLE: begin
          sx_q    <= '0;
          sy_q    <= '0;
          drain_q <= '0;
        end
        ST_CTR: begin
          dr_q <= -rad_s;
          dc_q <= -rad_s;
        end
        ST_SWEEP: begin
          if (dc_q == rad_s) begin
            dc_q <= -rad_s;
            dr_q <= dr_q + OFS_W'(1);
          end else begin
            dc_q <= dc_q + OFS_W'(1);
          end
        end
        ST_DRAIN: drain_q <= drain_q + 3'd1;
        default: ;
      endcase
    end
  end

  assign sum_valid_o = (state_q == ST_SEND);
  assign sum_o.zero  = zero_q;
  assign sum_o.sx    = sx_q;
  assign sum_o.sy    = sy_q;

endmodule

@@ hdl/etf_norm.sv @@
// ----------------------------------------------------------------------------
// etf_norm
// Scale the summed vector to unit length and hold it in the output register.
// ----------------------------------------------------------------------------
module etf_norm (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          sum_valid_i,
  input  etf_pkg::etf_sum_t             sum_i,
  output logic                          sum_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [etf_pkg::VEC_W-1:0] refined_x_o,
  output logic signed [etf_pkg::VEC_W-1:0] refined_y_o,
  output logic                          sum_was_zero_o
);
  import etf_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SHIFT = 3'd1;
  localparam logic [2:0] ST_SQ    = 3'd2;
  localparam logic [2:0] ST_ADD   = 3'd3;
  localparam logic [2:0] ST_ROOT  = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;
  localparam int Q_W = 15;
  localparam int N_W = 46;

  logic [2:0]       state_q;
  logic [SUM_W-1:0] ax_q, ay_q;
  logic             negx_q, negy_q;
  logic [59:0]      sqx_q, sqy_q;
  logic [SUM_W-1:0] n_q, res_q, bit_q;
  logic [N_W-1:0]   remx_q, remy_q, div_q;
  logic [Q_W-1:0]   qx_q, qy_q;
  logic [Q_W-1:0]   qx_d, qy_d;
  logic [3:0]       step_q;
  logic signed [VEC_W-1:0] ox_q, oy_q;
  logic             zero_q;

  logic [SUM_W-1:0] m;
  logic [SUM_W-1:0] trial;
  logic [31:0]      len;

  assign m     = (ax_q > ay_q) ? ax_q : ay_q;
  assign trial = res_q + bit_q;
  assign len   = res_q[31:0];
  // quotients with the current digit shifted in
  assign qx_d  = {qx_q[Q_W-2:0], remx_q >= div_q};
  assign qy_d  = {qy_q[Q_W-2:0], remy_q >= div_q};

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        ax_q   <= sum_i.sx[SUM_W-1] ? SUM_W'(-sum_i.sx) : SUM_W'(sum_i.sx);
        ay_q   <= sum_i.sy[SUM_W-1] ? SUM_W'(-sum_i.sy) : SUM_W'(sum_i.sy);
        negx_q <= sum_i.sx[SUM_W-1];
        negy_q <= sum_i.sy[SUM_W-1];
      end
      ST_SHIFT: begin
        if (m >= (SUM_W'(1) << 30)) begin
          ax_q <= ax_q >> 1;
          ay_q <= ay_q >> 1;
        end else if (m < (SUM_W'(1) << 29)) begin
          ax_q <= ax_q << 1;
          ay_q <= ay_q << 1;
        end
      end
      ST_SQ: begin
        sqx_q <= 60'(ax_q[29:0]) * 60'(ax_q[29:0]);
        sqy_q <= 60'(ay_q[29:0]) * 60'(ay_q[29:0]);
      end
      ST_ADD: begin
        n_q   <= SUM_W'(sqx_q) + SUM_W'(sqy_q);
        res_q <= '0;
        bit_q <= SUM_W'(1) << 62;
      end
      ST_ROOT: begin
        if (n_q >= trial) begin
          n_q   <= n_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
        // seed the divider once the last root digit lands
        remx_q <= N_W'({ax_q[29:0], 14'b0});
        remy_q <= N_W'({ay_q[29:0], 14'b0});
        step_q <= '0;
      end
      ST_DIV: begin
        if (step_q == 4'd0) begin
          remx_q <= remx_q + N_W'(len >> 1);
          remy_q <= remy_q + N_W'(len >> 1);
          div_q  <= N_W'(len) << (Q_W - 1);
        end else begin
          if (remx_q >= div_q) begin
            remx_q <= remx_q - div_q;
            qx_q   <= {qx_q[Q_W-2:0], 1'b1};
          end else begin
            qx_q   <= {qx_q[Q_W-2:0], 1'b0};
          end
          if (remy_q >= div_q) begin
            remy_q <= remy_q - div_q;
            qy_q   <= {qy_q[Q_W-2:0], 1'b1};
          end else begin
            qy_q   <= {qy_q[Q_W-2:0], 1'b0};
          end
          div_q <= div_q >> 1;
        end
        step_q <= step_q + 4'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      zero_q  <= 1'b0;
      ox_q    <= '0;
      oy_q    <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (sum_valid_i) begin
            if (sum_i.zero || (sum_i.sx == '0 && sum_i.sy == '0)) begin
              zero_q  <= 1'b1;
              ox_q    <= '0;
              oy_q    <= '0;
              state_q <= ST_OUT;
            end else begin
              zero_q  <= 1'b0;
              state_q <= ST_SHIFT;
            end
          end
        end
        ST_SHIFT: begin
          if (m < (SUM_W'(1) << 30) && m >= (SUM_W'(1) << 29)) state_q <= ST_SQ;
        end
        ST_SQ:   state_q <= ST_ADD;
        ST_ADD:  state_q <= ST_ROOT;
        ST_ROOT: if (bit_q == SUM_W'(1)) state_q <= ST_DIV;
        ST_DIV: begin
          if (step_q == 4'(Q_W)) begin
            ox_q    <= negx_q ? -VEC_W'({1'b0, qx_d}) : VEC_W'({1'b0, qx_d});
            oy_q    <= negy_q ? -VEC_W'({1'b0, qy_d}) : VEC_W'({1'b0, qy_d});
            state_q <= ST_OUT;
          end
        end
        ST_OUT:  if (!out_stall_i) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign sum_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o    = (state_q == ST_OUT);
  assign refined_x_o    = ox_q;
  assign refined_y_o    = oy_q;
  assign sum_was_zero_o = zero_q;

endmodule

@@ hdl/edge_tangent_flow_refine_core.sv @@
// Flow: a load is written to the frame store straight from the front queue when the
//   back end is idle. A query sweeps the window, drains the pipeline and is
//   normalized; a zero sum skips the normalizing steps, and a query outside the image
//   skips the sweep as well.
// Throughput: one item at a time in the back end; the window sweep reads the frame
//   store once per cycle and dominates. Loads pass one per cycle while the back end is idle.
// ----------------------------------------------------------------------------
// edge_tangent_flow_refine_core
// Edge tangent flow refinement over a stored tangent and magnitude frame.
// Reset: registers return to 512 x 512, radius 5; the frame store is not cleared.
// ----------------------------------------------------------------------------
module edge_tangent_flow_refine_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  etf_pkg::etf_func_e            func_i,
  input  logic [etf_pkg::COL_W-1:0]     col_i,
  input  logic [etf_pkg::ROW_W-1:0]     row_i,
  input  logic signed [etf_pkg::VEC_W-1:0] tangent_x_i,
  input  logic signed [etf_pkg::VEC_W-1:0] tangent_y_i,
  input  logic [etf_pkg::MAG_W-1:0]     magnitude_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [etf_pkg::VEC_W-1:0] refined_x_o,
  output logic signed [etf_pkg::VEC_W-1:0] refined_y_o,
  output logic                          sum_was_zero_o,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [etf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [etf_pkg::CFG_DAT_W-1:0] cfg_data_i
);
  import etf_pkg::*;

  logic [SIZE_W-1:0] width_q, height_q;
  logic [RAD_W-1:0]  radius_q;
  logic [SIZE_W-1:0] width_eff, height_eff;
  logic [RAD_W-1:0]  radius_eff;

  logic      cmd_valid;
  etf_cmd_t  cmd;
  logic      cmd_pop;
  logic      sum_valid;
  etf_sum_t  sum;
  logic      sum_ready;

  // Registers are writable at any time; the index beyond the list is dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIZE_W'(MAX_WIDTH);
      height_q <= SIZE_W'(MAX_HEIGHT);
      radius_q <= RAD_W'(5);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        CFG_RADIUS: radius_q <= cfg_data_i[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the used image to the store geometry.
  assign width_eff  = (width_q  > SIZE_W'(MAX_WIDTH))  ? SIZE_W'(MAX_WIDTH)  : width_q;
  assign height_eff = (height_q > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : height_q;
  assign radius_eff = (radius_q > RAD_W'(MAX_RADIUS))  ? RAD_W'(MAX_RADIUS)  : radius_q;

  // Front end: accept and classify, hold up to two items.
  etf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .col_i       (col_i),
    .row_i       (row_i),
    .tangent_x_i (tangent_x_i),
    .tangent_y_i (tangent_y_i),
    .magnitude_i (magnitude_i),
    .width_i     (width_eff),
    .height_i    (height_eff),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // Back end: write loads, sweep the window for queries.
  etf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .width_i     (width_eff),
    .height_i    (height_eff),
    .radius_i    (radius_eff),
    .sum_valid_o (sum_valid),
    .sum_o       (sum),
    .sum_ready_i (sum_ready)
  );

  // Normalize and hold the result until taken.
  etf_norm u_norm (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sum_valid_i    (sum_valid),
    .sum_i          (sum),
    .sum_ready_o    (sum_ready),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .refined_x_o    (refined_x_o),
    .refined_y_o    (refined_y_o),
    .sum_was_zero_o (sum_was_zero_o)
  );

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the edge tangent flow refine core: loads pixels
// into the frame store, queries refined tangents under many image sizes and
// radii, and compares every result with a bit-exact predictor.
// ----------------------------------------------------------------------------
module tb;
  import etf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // not a register
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int ITEM_TARGET    = 1950;

  typedef struct {
    etf_func_e          func;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [VEC_W-1:0]   tx;
    logic [VEC_W-1:0]   ty;
    logic [MAG_W-1:0]   mag;
  } pixel_item_t;

  typedef struct {
    logic [VEC_W-1:0] rx;
    logic [VEC_W-1:0] ry;
    logic             zero;
  } refined_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  etf_func_e            func_d = FUNC_LOAD;
  logic [COL_W-1:0]     col_d = '0;
  logic [ROW_W-1:0]     row_d = '0;
  logic [VEC_W-1:0]     tx_d = '0;
  logic [VEC_W-1:0]     ty_d = '0;
  logic [MAG_W-1:0]     mag_d = '0;

  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [VEC_W-1:0]     refined_x;
  logic [VEC_W-1:0]     refined_y;
  logic                 sum_was_zero;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  edge_tangent_flow_refine_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .func_i         (func_d),
    .col_i          (col_d),
    .row_i          (row_d),
    .tangent_x_i    (tx_d),
    .tangent_y_i    (ty_d),
    .magnitude_i    (mag_d),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .refined_x_o    (refined_x),
    .refined_y_o    (refined_y),
    .sum_was_zero_o (sum_was_zero),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always #10 clk_i = ~clk_i;

  // Predictor state: frame store copy, register copy, tanh table.
  logic [31:0]      tan_mem [STORE_DEPTH];
  logic [MAG_W-1:0] mag_mem [STORE_DEPTH];
  bit               loaded  [STORE_DEPTH];  // generator side: entry written
  logic [15:0]      tanh_q15 [TANH_SIZE];
  int unsigned      reg_w = 512, reg_h = 512, reg_r = 5;

  pixel_item_t pending_items [$];
  refined_t    refined_due [$];
  pixel_item_t cur;

  int  errors = 0;
  int  n_loads = 0, n_queries = 0, n_zero = 0, n_phases = 0, n_gen = 0;
  bit  calm = 1'b0;
  int  gap_cnt = 0, stall_cnt = 0, quiet_cycles = 0;

  // Refined tangent at one pixel under the current registers.
  function automatic refined_t refine_pixel(int col, int row);
    longint w, h, rad, sx, sy, cx, cy, cm, nx, ny, dot, wd, d, th, wgt;
    longint unsigned ax, ay, m, len, ad, idx, n, bitv;
    int r, c, a;
    refined_t res;
    w   = reg_w < MAX_WIDTH  ? reg_w : MAX_WIDTH;
    h   = reg_h < MAX_HEIGHT ? reg_h : MAX_HEIGHT;
    rad = reg_r < MAX_RADIUS ? reg_r : MAX_RADIUS;
    res = '{rx: '0, ry: '0, zero: 1'b1};
    if (col >= w || row >= h) return res;
    a  = row * MAX_WIDTH + col;
    cx = longint'($signed(tan_mem[a][15:0]));
    cy = longint'($signed(tan_mem[a][31:16]));
    cm = longint'(mag_mem[a]);
    sx = 0;
    sy = 0;
    for (int dr = -rad; dr <= rad; dr++) begin
      for (int dc = -rad; dc <= rad; dc++) begin
        r = row + dr;
        c = col + dc;
        if (dr * dr + dc * dc >= rad * rad) continue;
        if (r < 0 || r >= h || c < 0 || c >= w) continue;
        a   = r * MAX_WIDTH + c;
        nx  = longint'($signed(tan_mem[a][15:0]));
        ny  = longint'($signed(tan_mem[a][31:16]));
        dot = cx * nx + cy * ny;
        wd  = (dot < 0 ? -dot : dot) >>> 14;
        d   = longint'(mag_mem[a]) - cm;
        ad  = d < 0 ? -d : d;
        idx = (ad * TANH_SIZE) >> 12;
        if (idx >= TANH_SIZE) idx = TANH_SIZE - 1;
        th  = longint'(tanh_q15[idx]);
        if (d < 0) th = -th;
        wgt = wd * (32768 + th);
        if (dot <= 0) wgt = -wgt;
        sx += nx * wgt;
        sy += ny * wgt;
      end
    end
    if (sx == 0 && sy == 0) return res;
    ax = sx < 0 ? -sx : sx;
    ay = sy < 0 ? -sy : sy;
    m  = ax > ay ? ax : ay;
    while (m >= (64'd1 << 30)) begin ax >>= 1; ay >>= 1; m >>= 1; end
    while (m <  (64'd1 << 29)) begin ax <<= 1; ay <<= 1; m <<= 1; end
    // bitwise integer square root
    n    = ax * ax + ay * ay;
    len  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= len + bitv) begin
        n   = n - (len + bitv);
        len = (len >> 1) + bitv;
      end else begin
        len = len >> 1;
      end
      bitv >>= 2;
    end
    if (len == 0) len = 1;
    cx = longint'((ax * 16384 + len / 2) / len);
    cy = longint'((ay * 16384 + len / 2) / len);
    if (sx < 0) cx = -cx;
    if (sy < 0) cy = -cy;
    res.rx   = cx[15:0];
    res.ry   = cy[15:0];
    res.zero = 1'b0;
    return res;
  endfunction

  // True when every in-image neighbor of (col,row) has been loaded.
  function automatic bit window_loaded(int col, int row);
    int w, h, rad, r, c;
    w   = reg_w < MAX_WIDTH  ? reg_w : MAX_WIDTH;
    h   = reg_h < MAX_HEIGHT ? reg_h : MAX_HEIGHT;
    rad = reg_r < MAX_RADIUS ? reg_r : MAX_RADIUS;
    if (col >= w || row >= h) return 1'b1;
    for (int dr = -rad; dr <= rad; dr++) begin
      for (int dc = -rad; dc <= rad; dc++) begin
        r = row + dr;
        c = col + dc;
        if (dr * dr + dc * dc >= rad * rad) continue;
        if (r < 0 || r >= h || c < 0 || c >= w) continue;
        if (!loaded[r * MAX_WIDTH + c]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Driver: present queued items, hold while stalled, idle in bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_cnt  <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (cur.func == FUNC_LOAD) begin
          tan_mem[{cur.row, cur.col}] = {cur.ty, cur.tx};
          mag_mem[{cur.row, cur.col}] = cur.mag;
          n_loads++;
        end else begin
          refined_due.push_back(refine_pixel(cur.col, cur.row));
          n_queries++;
        end
      end
      if (in_valid && in_stall) begin
        // hold the stalled item
      end else if (gap_cnt > 0) begin
        gap_cnt  <= gap_cnt - 1;
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        gap_cnt  <= $urandom_range(0, 6);
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        cur     = pending_items.pop_front();
        func_d  <= cur.func;
        col_d   <= cur.col;
        row_d   <= cur.row;
        tx_d    <= cur.tx;
        ty_d    <= cur.ty;
        mag_d   <= cur.mag;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each result against the oldest prediction; stall in bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    refined_t exp_res;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_cnt <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (refined_due.size() == 0) begin
          $error("result with no query outstanding");
          errors++;
        end else begin
          exp_res = refined_due.pop_front();
          if (exp_res.zero) n_zero++;
          if (refined_x !== exp_res.rx) begin
            $error("refined_x expected %0d got %0d", $signed(exp_res.rx), $signed(refined_x));
            errors++;
          end
          if (refined_y !== exp_res.ry) begin
            $error("refined_y expected %0d got %0d", $signed(exp_res.ry), $signed(refined_y));
            errors++;
          end
          if (sum_was_zero !== exp_res.zero) begin
            $error("sum_was_zero expected %0b got %0b", exp_res.zero, sum_was_zero);
            errors++;
          end
        end
      end
      if (calm) begin
        out_stall <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt <= stall_cnt - 1;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_cnt <= $urandom_range(0, 6);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: count cycles with no handshake on any channel.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  // Wait until every generated item is accepted and every result is back,
  // then let a trailing load settle.
  task automatic wait_idle();
    while (n_loads + n_queries < n_gen || refined_due.size() > 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_WIDTH:  reg_w = data;
      CFG_HEIGHT: reg_h = data;
      CFG_RADIUS: reg_r = data[RAD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic push_load(int col, int row, logic [15:0] tx, logic [15:0] ty,
                           logic [11:0] mag);
    pixel_item_t it;
    it = '{func: FUNC_LOAD, col: COL_W'(col), row: ROW_W'(row), tx: tx, ty: ty, mag: mag};
    loaded[row * MAX_WIDTH + col] = 1'b1;
    pending_items.push_back(it);
    n_gen++;
  endtask

  task automatic push_query(int col, int row);
    pixel_item_t it;
    it = '{func: FUNC_QUERY, col: COL_W'(col), row: ROW_W'(row), tx: VEC_W'($urandom),
           ty: VEC_W'($urandom), mag: MAG_W'($urandom)};
    pending_items.push_back(it);
    n_gen++;
  endtask

  // Stimulus: directed corners first, then random phases of sizes and radii.
  initial begin
    logic [63:0] x, y, sum, term, num, den;
    logic [15:0] vec_edge [5];
    int w, h, c0, r0, span_c, span_r, col, row, tries;
    bit placed;

    // tanh table, exp(2x) from a truncated Taylor series in Q.30
    for (int k = 0; k < TANH_SIZE; k++) begin
      x    = (64'(k) << 30) / TANH_SIZE;
      y    = 2 * x;
      sum  = 0;
      term = 64'd1 << 30;
      for (int t = 1; t <= 30; t++) begin
        sum  = sum + term;
        term = ((term * y) >> 30) / 64'(t);
      end
      num = (sum - (64'd1 << 30)) << 15;
      den = sum + (64'd1 << 30);
      tanh_q15[k] = 16'((num + den / 2) / den);
    end
    vec_edge = '{16'h4000, 16'hC000, 16'h7FFF, 16'h8000, 16'h0001};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: 4x4 image, extreme vectors and magnitudes, centre-only radius.
    write_reg(CFG_WIDTH, 10'd4);
    write_reg(CFG_HEIGHT, 10'd4);
    write_reg(CFG_RADIUS, 10'd1);
    for (int i = 0; i < 16; i++) begin
      if (i == 0) push_load(0, 0, 16'h0000, 16'h0000, 12'd0);
      else push_load(i % 4, i / 4, vec_edge[i % 5], vec_edge[(i + 2) % 5],
                     (i % 2) ? 12'hFFF : 12'h000);
    end
    push_query(0, 0);        // zero centre tangent: zero sum
    push_query(3, 3);
    push_query(4, 0);        // column beyond the image
    push_query(0, 4);        // row beyond the image
    push_query(511, 511);
    wait_idle();
    write_reg(CFG_RADIUS, 10'h3FF);   // top bits dropped: radius 7
    push_query(0, 0);
    push_query(3, 3);
    push_query(2, 1);
    wait_idle();
    write_reg(CFG_RADIUS, 10'd8);     // masks to zero radius
    write_reg(CFG_SPARE, 10'h2AA);    // ignored index
    push_query(1, 1);
    wait_idle();
    write_reg(CFG_HEIGHT, 10'd0);     // empty image: every query outside
    push_query(0, 0);
    wait_idle();

    // Random phases; settle with no idling over the last stretch.
    while (n_gen < ITEM_TARGET) begin
      if (n_gen > ITEM_TARGET - 250) calm = 1'b1;
      n_phases++;
      write_reg(CFG_WIDTH,  ($urandom_range(0, 7) == 0) ? $urandom_range(512, 1023)
                                                       : $urandom_range(1, 14));
      write_reg(CFG_HEIGHT, ($urandom_range(0, 7) == 0) ? $urandom_range(512, 1023)
                                                       : $urandom_range(1, 14));
      write_reg(CFG_RADIUS, ($urandom_range(0, 127) << RAD_W) | $urandom_range(0, 7));
      w = reg_w < MAX_WIDTH  ? reg_w : MAX_WIDTH;
      h = reg_h < MAX_HEIGHT ? reg_h : MAX_HEIGHT;
      // load the whole image, or a 12-wide patch at one end of a large one
      span_c = w > 14 ? 12 : w;
      span_r = h > 14 ? 12 : h;
      c0 = (w > 14 && $urandom_range(0, 1)) ? MAX_WIDTH - span_c : 0;
      r0 = (h > 14 && $urandom_range(0, 1)) ? MAX_HEIGHT - span_r : 0;
      for (int r = 0; r < span_r; r++)
        for (int c = 0; c < span_c; c++)
          push_load(c0 + c, r0 + r, $urandom, $urandom, $urandom);
      for (int i = 0; i < 40; i++) begin
        case ($urandom_range(0, 9))
          0: push_load($urandom_range(0, 511), $urandom_range(0, 511),
                       $urandom, $urandom, $urandom);
          1, 2: push_load(c0 + $urandom_range(0, span_c - 1), r0 + $urandom_range(0, span_r - 1),
                          $urandom, $urandom, $urandom);
          default: begin
            placed = 1'b0;
            for (tries = 0; tries < 8 && !placed; tries++) begin
              col = c0 + $urandom_range(0, span_c - 1);
              row = r0 + $urandom_range(0, span_r - 1);
              if (window_loaded(col, row)) begin
                push_query(col, row);
                placed = 1'b1;
              end
            end
            if (!placed && w < MAX_WIDTH) push_query($urandom_range(w, 511), $urandom_range(0, 511));
            else if (!placed && h < MAX_HEIGHT) push_query($urandom_range(0, 511), $urandom_range(h, 511));
          end
        endcase
      end
      wait_idle();
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (refined_due.size() != 0) errors++;
    $display("Covered %0d loads and %0d queries (%0d zero results) over %0d random settings.",
             n_loads, n_queries, n_zero, n_phases);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
